// ----- src/radar_measurement_jacobian_core_assert.svh -----
// Assertion macros shared by the radar measurement Jacobian RTL
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH

// cond must always be followed by prop on the same edge
`define RMJ_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond must never hold
`define RMJ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ----- src/rmj_pkg.sv -----
// Shared constants and payload types for the radar measurement Jacobian core
package rmj_pkg;

   localparam int DATA_W      = 32;                // Q16.16 word
   localparam int FRAC_BITS   = 16;
   localparam int LIM_W       = 17;                // near-zero limit register
   localparam int SQ_W        = 2 * DATA_W;        // squares, r2, velocity cross terms
   localparam int ROOT_W      = DATA_W;            // floor(sqrt(r2))
   localparam int NUM_W       = 111;               // widest dividend: |p| * dmag << FRAC_BITS
   localparam int DEN_W       = 96;                // widest divisor: r2 * r
   localparam int QUOT_BITS   = 33;                // one above the signed range, for saturation
   localparam int CMP_W       = DEN_W + QUOT_BITS;
   localparam int DIV_LATENCY = QUOT_BITS + 2;     // capture, one stage per bit, saturate
   localparam int ADDR_W      = 3;
   localparam int CSR_W       = 32;

   // word index of the near-zero limit register
   localparam logic [ADDR_W-3:0] REG_LIMIT = '0;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
   } rmj_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_by_px;
      logic signed [DATA_W-1:0] range_by_py;
      logic signed [DATA_W-1:0] bearing_by_px;
      logic signed [DATA_W-1:0] bearing_by_py;
      logic signed [DATA_W-1:0] rate_by_px;
      logic signed [DATA_W-1:0] rate_by_py;
      logic                     position_adjusted;
   } rmj_rsp_type;

endpackage

// ----- src/rmj_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating signed result
module rmj_div
   import rmj_pkg::*;
(
   input  logic                     clock,
   input  logic [NUM_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,
   input  logic                     neg,
   output logic signed [DATA_W-1:0] quot
);

   localparam logic [QUOT_BITS-1:0] POS_MAX = QUOT_BITS'((64'(1) << (DATA_W - 1)) - 64'(1));
   localparam logic [QUOT_BITS-1:0] NEG_MAX = QUOT_BITS'(64'(1) << (DATA_W - 1));

   logic [NUM_W-1:0]     rem_ff [0:QUOT_BITS];
   logic [DEN_W-1:0]     den_ff [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] q_ff   [0:QUOT_BITS];
   logic                 neg_ff [0:QUOT_BITS];
   logic                 ovf_ff [0:QUOT_BITS];
   logic                 ovf_in;
   logic [DATA_W-1:0]    quot_ff;
   logic [DATA_W-1:0]    quot_in;
   logic [QUOT_BITS-1:0] q_last;

   // quotient would need more than QUOT_BITS bits
   assign ovf_in = {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {QUOT_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      neg_ff[0] <= neg;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_bit
      localparam int BIT = QUOT_BITS - k;
      logic [CMP_W-1:0]     rem_ext;
      logic [CMP_W-1:0]     trial;
      logic [CMP_W-1:0]     diff;
      logic                 hit;
      logic [NUM_W-1:0]     rem_in;
      logic [QUOT_BITS-1:0] q_in;

      always_comb begin
         rem_ext   = {{(CMP_W-NUM_W){1'b0}}, rem_ff[k-1]};
         trial     = {{QUOT_BITS{1'b0}}, den_ff[k-1]} << BIT;
         hit       = rem_ext >= trial;
         diff      = rem_ext - trial;
         rem_in    = hit ? diff[NUM_W-1:0] : rem_ff[k-1];
         q_in      = q_ff[k-1];
         q_in[BIT] = hit;
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_ff[k-1];
         q_ff[k]   <= q_in;
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign q_last = q_ff[QUOT_BITS];

   always_comb begin
      if (neg_ff[QUOT_BITS]) begin
         if (ovf_ff[QUOT_BITS] || q_last > NEG_MAX) begin
            quot_in = NEG_MAX[DATA_W-1:0];
         end else begin
            quot_in = ~q_last[DATA_W-1:0] + 1'b1;
         end
      end else begin
         if (ovf_ff[QUOT_BITS] || q_last > POS_MAX) begin
            quot_in = POS_MAX[DATA_W-1:0];
         end else begin
            quot_in = q_last[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ----- src/radar_measurement_jacobian_core.sv -----
// Top level: radar measurement Jacobian, Q16.16, fully pipelined
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-----------------------------
//  request   | start, busy, req_data                   | taken when start && !busy
//  result    | rsp_strobe, rsp_data                    | one-cycle strobe, no back-pressure
//  registers | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// A request can be taken every cycle; busy is always low.
// The strobe follows the taken request through four entry stages, 32 square-root stages
// (one root bit each), two multiply stages and a 35-stage divider.
// Synchronous reset clears the valid bits and sets the limit to 1; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
`include "radar_measurement_jacobian_core_assert.svh"

module radar_measurement_jacobian_core
   import rmj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmj_req_type       req_data,
   output logic              rsp_strobe,
   output rmj_rsp_type       rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   typedef struct packed {
      logic [DATA_W-1:0] apx;
      logic [DATA_W-1:0] apy;
      logic              x_neg;
      logic              y_neg;
      logic              dneg;
      logic              flag;
      logic [SQ_W-1:0]   dmag;
      logic [SQ_W-1:0]   r2;
   } carry_type;

   // ---------------- register port ----------------
   logic             csr_wr;
   logic [LIM_W-1:0] limit_ff;
   logic [LIM_W-1:0] lim_eff;
   logic [DATA_W-1:0] lim_w;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_W'(1);
      end else if (csr_wr && paddr[ADDR_W-1:2] == REG_LIMIT) begin
         limit_ff <= pwdata[LIM_W-1:0];
      end
   end

   assign prdata  = (paddr[ADDR_W-1:2] == REG_LIMIT) ?
                    {{(CSR_W-LIM_W){1'b0}}, limit_ff} : '0;
   assign lim_eff = (limit_ff == '0) ? LIM_W'(1) : limit_ff;
   assign lim_w   = {{(DATA_W-LIM_W){1'b0}}, lim_eff};

   // ---------------- stage A: capture ----------------
   logic        a_valid_ff;
   rmj_req_type a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_req_ff <= req_data;
   end

   // ---------------- stage B: near-origin substitution ----------------
   logic [DATA_W-1:0] magx, magy;
   logic              near;
   logic [DATA_W-1:0] b_apx_in, b_apy_in;
   logic signed [DATA_W-1:0] b_px_in, b_py_in;

   logic                     b_valid_ff, b_flag_ff, b_xneg_ff, b_yneg_ff;
   logic [DATA_W-1:0]        b_apx_ff, b_apy_ff;
   logic signed [DATA_W-1:0] b_px_ff, b_py_ff, b_vx_ff, b_vy_ff;

   always_comb begin
      magx     = a_req_ff.pos_x[DATA_W-1] ? (~a_req_ff.pos_x + 1'b1) : a_req_ff.pos_x;
      magy     = a_req_ff.pos_y[DATA_W-1] ? (~a_req_ff.pos_y + 1'b1) : a_req_ff.pos_y;
      near     = (magx < lim_w) && (magy < lim_w);
      b_apx_in = near ? lim_w : magx;
      b_apy_in = near ? lim_w : magy;
      // zero counts as positive, so the sign bit alone picks the substitute
      if (near) begin
         b_px_in = a_req_ff.pos_x[DATA_W-1] ? (~lim_w + 1'b1) : lim_w;
         b_py_in = a_req_ff.pos_y[DATA_W-1] ? (~lim_w + 1'b1) : lim_w;
      end else begin
         b_px_in = a_req_ff.pos_x;
         b_py_in = a_req_ff.pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_flag_ff <= near;
      b_xneg_ff <= a_req_ff.pos_x[DATA_W-1];
      b_yneg_ff <= a_req_ff.pos_y[DATA_W-1];
      b_apx_ff  <= b_apx_in;
      b_apy_ff  <= b_apy_in;
      b_px_ff   <= b_px_in;
      b_py_ff   <= b_py_in;
      b_vx_ff   <= a_req_ff.vel_x;
      b_vy_ff   <= a_req_ff.vel_y;
   end

   // ---------------- stage C: squares and cross products ----------------
   logic                   c_valid_ff, c_flag_ff, c_xneg_ff, c_yneg_ff;
   logic [DATA_W-1:0]      c_apx_ff, c_apy_ff;
   logic [SQ_W-1:0]        c_xx_ff, c_yy_ff;
   logic signed [SQ_W-1:0] c_p1_ff, c_p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_flag_ff <= b_flag_ff;
      c_xneg_ff <= b_xneg_ff;
      c_yneg_ff <= b_yneg_ff;
      c_apx_ff  <= b_apx_ff;
      c_apy_ff  <= b_apy_ff;
      c_xx_ff   <= SQ_W'(b_apx_ff) * SQ_W'(b_apx_ff);
      c_yy_ff   <= SQ_W'(b_apy_ff) * SQ_W'(b_apy_ff);
      c_p1_ff   <= SQ_W'(b_vx_ff) * SQ_W'(b_py_ff);
      c_p2_ff   <= SQ_W'(b_vy_ff) * SQ_W'(b_px_ff);
   end

   // ---------------- stage D: r2 and |vx py - vy px| ----------------
   logic [SQ_W:0] cross_diff, cross_abs;
   carry_type     d_carry_in;

   always_comb begin
      cross_diff        = {c_p1_ff[SQ_W-1], c_p1_ff} - {c_p2_ff[SQ_W-1], c_p2_ff};
      cross_abs         = cross_diff[SQ_W] ? (~cross_diff + 1'b1) : cross_diff;
      d_carry_in.apx    = c_apx_ff;
      d_carry_in.apy    = c_apy_ff;
      d_carry_in.x_neg  = c_xneg_ff;
      d_carry_in.y_neg  = c_yneg_ff;
      d_carry_in.dneg   = cross_diff[SQ_W];
      d_carry_in.flag   = c_flag_ff;
      d_carry_in.dmag   = cross_abs[SQ_W-1:0];
      d_carry_in.r2     = c_xx_ff + c_yy_ff;
   end

   // ---------------- square root, one root bit per stage ----------------
   logic              sq_valid_ff [0:ROOT_W];
   carry_type         sq_carry_ff [0:ROOT_W];
   logic [SQ_W-1:0]   sq_rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff  [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= c_valid_ff;
      end
      sq_carry_ff[0] <= d_carry_in;
      sq_rem_ff[0]   <= d_carry_in.r2;
      sq_root_ff[0]  <= '0;
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      localparam int BIT = ROOT_W - k;
      logic [SQ_W:0]     trial;
      logic              hit;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
      always_comb begin
         trial = ({{(SQ_W+1-ROOT_W){1'b0}}, sq_root_ff[k-1]} << (BIT + 1))
               + ((SQ_W+1)'(1) << (2 * BIT));
         hit          = {1'b0, sq_rem_ff[k-1]} >= trial;
         rem_in       = hit ? (sq_rem_ff[k-1] - trial[SQ_W-1:0]) : sq_rem_ff[k-1];
         root_in      = sq_root_ff[k-1];
         root_in[BIT] = hit;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
         sq_carry_ff[k] <= sq_carry_ff[k-1];
         sq_rem_ff[k]   <= rem_in;
         sq_root_ff[k]  <= root_in;
      end
   end

   // ---------------- M1: 32x32 partial products ----------------
   carry_type         sq_out;
   logic [ROOT_W-1:0] sq_root;
   logic              m1_valid_ff;
   carry_type         m1_carry_ff;
   logic [ROOT_W-1:0] m1_root_ff;
   logic [SQ_W-1:0]   m1_rr_lo_ff, m1_rr_hi_ff;
   logic [SQ_W-1:0]   m1_nx_lo_ff, m1_nx_hi_ff, m1_ny_lo_ff, m1_ny_hi_ff;

   assign sq_out  = sq_carry_ff[ROOT_W];
   assign sq_root = sq_root_ff[ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= sq_valid_ff[ROOT_W];
      end
      m1_carry_ff <= sq_out;
      m1_root_ff  <= sq_root;
      m1_rr_lo_ff <= SQ_W'(sq_root) * SQ_W'(sq_out.r2[DATA_W-1:0]);
      m1_rr_hi_ff <= SQ_W'(sq_root) * SQ_W'(sq_out.r2[SQ_W-1:DATA_W]);
      m1_nx_lo_ff <= SQ_W'(sq_out.apx) * SQ_W'(sq_out.dmag[DATA_W-1:0]);
      m1_nx_hi_ff <= SQ_W'(sq_out.apx) * SQ_W'(sq_out.dmag[SQ_W-1:DATA_W]);
      m1_ny_lo_ff <= SQ_W'(sq_out.apy) * SQ_W'(sq_out.dmag[DATA_W-1:0]);
      m1_ny_hi_ff <= SQ_W'(sq_out.apy) * SQ_W'(sq_out.dmag[SQ_W-1:DATA_W]);
   end

   // ---------------- M2: combine partial products ----------------
   logic              m2_valid_ff;
   carry_type         m2_carry_ff;
   logic [ROOT_W-1:0] m2_root_ff;
   logic [DEN_W-1:0]  m2_r3_ff, m2_nx_ff, m2_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      m2_carry_ff <= m1_carry_ff;
      m2_root_ff  <= m1_root_ff;
      m2_r3_ff    <= DEN_W'(m1_rr_lo_ff) + (DEN_W'(m1_rr_hi_ff) << DATA_W);
      m2_nx_ff    <= DEN_W'(m1_nx_lo_ff) + (DEN_W'(m1_nx_hi_ff) << DATA_W);
      m2_ny_ff    <= DEN_W'(m1_ny_lo_ff) + (DEN_W'(m1_ny_hi_ff) << DATA_W);
   end

   // ---------------- dividers ----------------
   logic [NUM_W-1:0] num_rx, num_ry, num_bx, num_by, num_tx, num_ty;
   logic [DEN_W-1:0] den_r, den_r2;
   logic signed [DATA_W-1:0] q_rx, q_ry, q_bx, q_by, q_tx, q_ty;

   always_comb begin
      num_rx = {{(NUM_W-DATA_W-FRAC_BITS){1'b0}}, m2_carry_ff.apx, {FRAC_BITS{1'b0}}};
      num_ry = {{(NUM_W-DATA_W-FRAC_BITS){1'b0}}, m2_carry_ff.apy, {FRAC_BITS{1'b0}}};
      num_bx = {{(NUM_W-DATA_W-2*FRAC_BITS){1'b0}}, m2_carry_ff.apy, {(2*FRAC_BITS){1'b0}}};
      num_by = {{(NUM_W-DATA_W-2*FRAC_BITS){1'b0}}, m2_carry_ff.apx, {(2*FRAC_BITS){1'b0}}};
      num_tx = {m2_ny_ff[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      num_ty = {m2_nx_ff[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      den_r  = {{(DEN_W-ROOT_W){1'b0}}, m2_root_ff};
      den_r2 = {{(DEN_W-SQ_W){1'b0}}, m2_carry_ff.r2};
   end

   rmj_div u_div_rx (.clock(clock), .num(num_rx), .den(den_r),
                     .neg(m2_carry_ff.x_neg), .quot(q_rx));
   rmj_div u_div_ry (.clock(clock), .num(num_ry), .den(den_r),
                     .neg(m2_carry_ff.y_neg), .quot(q_ry));
   rmj_div u_div_bx (.clock(clock), .num(num_bx), .den(den_r2),
                     .neg(!m2_carry_ff.y_neg), .quot(q_bx));
   rmj_div u_div_by (.clock(clock), .num(num_by), .den(den_r2),
                     .neg(m2_carry_ff.x_neg), .quot(q_by));
   rmj_div u_div_tx (.clock(clock), .num(num_tx), .den(m2_r3_ff),
                     .neg(m2_carry_ff.y_neg != m2_carry_ff.dneg), .quot(q_tx));
   rmj_div u_div_ty (.clock(clock), .num(num_ty), .den(m2_r3_ff),
                     .neg(m2_carry_ff.x_neg == m2_carry_ff.dneg), .quot(q_ty));

   // valid and flag ride alongside the dividers
   logic dv_valid_ff [0:DIV_LATENCY-1];
   logic dv_flag_ff  [0:DIV_LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= m2_valid_ff;
      end
      dv_flag_ff[0] <= m2_carry_ff.flag;
   end

   for (genvar j = 1; j < DIV_LATENCY; j++) begin : g_dv
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
         dv_flag_ff[j] <= dv_flag_ff[j-1];
      end
   end

   assign rsp_strobe                  = dv_valid_ff[DIV_LATENCY-1];
   assign rsp_data.range_by_px        = q_rx;
   assign rsp_data.range_by_py        = q_ry;
   assign rsp_data.bearing_by_px      = q_bx;
   assign rsp_data.bearing_by_py      = q_by;
   assign rsp_data.rate_by_px         = q_tx;
   assign rsp_data.rate_by_py         = q_ty;
   assign rsp_data.position_adjusted  = dv_flag_ff[DIV_LATENCY-1];

   // ---------------- assertions ----------------
   `RMJ_ASSERT_IMPLY(a_subst_uses_limit, clock, reset, b_valid_ff && b_flag_ff, b_apx_ff == $past(lim_w) && b_apy_ff == $past(lim_w), "substituted position does not equal the limit")
   `RMJ_ASSERT_IMPLY(a_root_not_high, clock, reset, sq_valid_ff[ROOT_W], (SQ_W'(sq_root) * SQ_W'(sq_root)) <= sq_out.r2, "square root exceeds floor")
   `RMJ_ASSERT_NEVER(a_adjusted_zero_range, clock, reset, rsp_strobe && rsp_data.position_adjusted && (rsp_data.range_by_px == '0 || rsp_data.range_by_py == '0), "adjusted position gave a zero range term")

endmodule
